// ----- rtl/lmpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpq_pkg
// Shared types, codes and sizes of the linear move planner queue.
// ----------------------------------------------------------------------------
package lmpq_pkg;

	// move store size
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// fixed widths of the fields
	localparam int COORD_W = 32;
	localparam int VEL_W   = 24;
	localparam int LEN_W   = 33;
	localparam int SUM_W   = 66;
	localparam int PROD_W  = 64;

	// iteration counts of the shared units
	localparam int ROOT_STEPS = 33;
	localparam int DIV_STEPS  = 24;

	// reset values of the speed registers, Q8.16
	localparam logic [VEL_W-1:0] RAPID_SPEED_RESET = 24'd786432;
	localparam logic [VEL_W-1:0] FEED_SPEED_RESET  = 24'd393216;

	// register indexes
	localparam logic [1:0] REG_RAPID_SPEED = 2'd0;
	localparam logic [1:0] REG_FEED_SPEED  = 2'd1;
	localparam logic [1:0] REG_RAPID_ACCEL = 2'd2;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_RAPID = 2'd1,
		CMD_FEED  = 2'd2,
		CMD_DONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_ISSUED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_SET  = 2'd0,
		K_MOVE = 2'd1,
		K_DONE = 2'd2
	} kind_t;

	// classified command handed from front to back
	typedef struct packed {
		kind_t                kind;
		logic                 rapid;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
	} item_t;

	// one planned move: flags bit 0..2 directions, bit 3 rapid
	typedef struct packed {
		logic [3:0]                 flags;
		logic [2:0][COORD_W-1:0]    travel;
		logic [2:0][VEL_W-1:0]      vel;
	} entry_t;

	typedef struct packed {
		status_t                    status;
		logic [2:0]                 dir;
		logic [2:0][COORD_W-1:0]    travel;
		logic [2:0][VEL_W-1:0]      vel;
		logic [VEL_W-1:0]           accel;
	} result_t;

	// circular pointer advance for any depth
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/linear_move_planner_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_move_planner_queue
// Three-axis straight move planner with a queue of planned moves.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    command, target_x, target_y, target_z
//  out      out_valid/out_stall  status, dir_*, dist_*, vel_*, accel
//  cfg      cfg_we               cfg_index, cfg_data
//
//  a queued move runs a 33-step root and, unless its length is zero, three
//  24-step divides on the shared units, plus the squares on one multiplier.
//  the front buffers two commands; the output register holds one result.
//  the move store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module linear_move_planner_queue (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          command,
	input  wire logic signed [lmpq_pkg::COORD_W-1:0] target_x,
	input  wire logic signed [lmpq_pkg::COORD_W-1:0] target_y,
	input  wire logic signed [lmpq_pkg::COORD_W-1:0] target_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [1:0]                               status,
	output logic                                     dir_x,
	output logic                                     dir_y,
	output logic                                     dir_z,
	output logic [lmpq_pkg::COORD_W-1:0]             dist_x,
	output logic [lmpq_pkg::COORD_W-1:0]             dist_y,
	output logic [lmpq_pkg::COORD_W-1:0]             dist_z,
	output logic [lmpq_pkg::VEL_W-1:0]               vel_x,
	output logic [lmpq_pkg::VEL_W-1:0]               vel_y,
	output logic [lmpq_pkg::VEL_W-1:0]               vel_z,
	output logic [lmpq_pkg::VEL_W-1:0]               accel,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [lmpq_pkg::VEL_W-1:0]          cfg_data
);

	localparam int CW = lmpq_pkg::COORD_W;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_SQ_MUL, S_SQ_ACC, S_ROOT_GO, S_ROOT,
		S_VMUL, S_VDIV_GO, S_VDIV, S_WRITE, S_READ, S_EMIT
	} state_t;

	state_t                          state_q;
	logic                            item_valid;
	lmpq_pkg::item_t                 item;
	logic                            item_pop;
	lmpq_pkg::item_t                 cur_q;

	logic [lmpq_pkg::VEL_W-1:0]      rapid_speed_q;
	logic [lmpq_pkg::VEL_W-1:0]      feed_speed_q;
	logic [lmpq_pkg::VEL_W-1:0]      rapid_accel_q;

	logic [CW-1:0]                   pos_q [3];
	logic [CW-1:0]                   mag_q [3];
	logic [2:0]                      dirs_q;
	logic [1:0]                      ax_q;
	logic [lmpq_pkg::PROD_W-1:0]     prod_q;
	logic [lmpq_pkg::SUM_W-1:0]      sum_q;
	logic [lmpq_pkg::LEN_W-1:0]      len_q;
	logic [lmpq_pkg::VEL_W-1:0]      vel_q [3];

	logic [lmpq_pkg::PTR_W-1:0]      head_q;
	logic [lmpq_pkg::PTR_W-1:0]      tail_q;
	logic [lmpq_pkg::CNT_W-1:0]      count_q;

	lmpq_pkg::entry_t                mem [lmpq_pkg::QUEUE_DEPTH];
	lmpq_pkg::entry_t                rd_q;
	lmpq_pkg::entry_t                wr_entry;

	lmpq_pkg::result_t               res_q;
	lmpq_pkg::result_t               out_q;
	logic                            out_valid_q;
	logic                            emit_go;

	logic [CW-1:0]                   mul_a;
	logic [CW-1:0]                   mul_b;
	logic [CW-1:0]                   tgt [3];
	logic [CW:0]                     diff [3];
	logic [lmpq_pkg::VEL_W-1:0]      speed;
	logic                            sq_done;
	logic [lmpq_pkg::LEN_W-1:0]      sq_root;
	logic                            dv_done;
	logic [lmpq_pkg::VEL_W-1:0]      dv_quot;
	logic                            q_full;

	// front: command intake and classification
	lmpq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.target_x   (target_x),
		.target_y   (target_y),
		.target_z   (target_z),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// shared root and divide units
	lmpq_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_ROOT_GO),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	lmpq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_VDIV_GO),
		.dividend (prod_q[lmpq_pkg::VEL_W+31:0]),
		.divisor  (len_q),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rapid_speed_q <= lmpq_pkg::RAPID_SPEED_RESET;
			feed_speed_q  <= lmpq_pkg::FEED_SPEED_RESET;
			rapid_accel_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lmpq_pkg::REG_RAPID_SPEED: rapid_speed_q <= cfg_data;
				lmpq_pkg::REG_FEED_SPEED:  feed_speed_q  <= cfg_data;
				lmpq_pkg::REG_RAPID_ACCEL: rapid_accel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// axis differences against the held position
	always_comb begin
		tgt[0] = cur_q.x;
		tgt[1] = cur_q.y;
		tgt[2] = cur_q.z;
		for (int a = 0; a < 3; a++) begin
			diff[a] = {pos_q[a][CW-1], pos_q[a]} - {tgt[a][CW-1], tgt[a]};
		end
	end

	// shared multiplier operands
	always_comb begin
		speed = cur_q.rapid ? rapid_speed_q : feed_speed_q;
		mul_a = mag_q[ax_q];
		if (state_q == S_VMUL) begin
			mul_b = {{(CW - lmpq_pkg::VEL_W){1'b0}}, speed};
		end else begin
			mul_b = mag_q[ax_q];
		end
	end

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign q_full   = (count_q == lmpq_pkg::CNT_W'(lmpq_pkg::QUEUE_DEPTH));
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		wr_entry.flags = {cur_q.rapid, dirs_q};
		for (int a = 0; a < 3; a++) begin
			wr_entry.travel[a] = mag_q[a];
			wr_entry.vel[a]    = vel_q[a];
		end
	end

	// move store
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			mem[tail_q] <= wr_entry;
		end
		rd_q <= mem[head_q];
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// back sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			pos_q       <= '{default: '0};
			mag_q       <= '{default: '0};
			vel_q       <= '{default: '0};
			dirs_q      <= '0;
			ax_q        <= '0;
			prod_q      <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cur_q <= item;
						unique case (item.kind)
							lmpq_pkg::K_SET: begin
								pos_q[0]     <= item.x;
								pos_q[1]     <= item.y;
								pos_q[2]     <= item.z;
								res_q.status <= lmpq_pkg::ST_ACCEPTED;
								state_q      <= S_EMIT;
							end
							lmpq_pkg::K_MOVE: begin
								if (q_full) begin
									res_q.status <= lmpq_pkg::ST_FULL;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_PREP;
								end
							end
							default: begin
								if (count_q == '0) begin
									res_q.status <= lmpq_pkg::ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_READ;
								end
							end
						endcase
					end
				end
				S_PREP: begin
					for (int a = 0; a < 3; a++) begin
						mag_q[a] <= diff[a][CW] ? CW'(-diff[a]) : diff[a][CW-1:0];
					end
					dirs_q  <= {diff[2][CW], ~diff[1][CW], ~diff[0][CW]};
					sum_q   <= '0;
					ax_q    <= '0;
					state_q <= S_SQ_MUL;
				end
				S_SQ_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					sum_q <= sum_q + {{(lmpq_pkg::SUM_W - lmpq_pkg::PROD_W){1'b0}}, prod_q};
					if (ax_q == 2'd2) begin
						state_q <= S_ROOT_GO;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done) begin
						len_q   <= sq_root;
						ax_q    <= '0;
						state_q <= S_VMUL;
					end
				end
				S_VMUL: begin
					if (len_q == '0) begin
						// zero length move: no velocity on any axis
						vel_q[ax_q] <= '0;
						if (ax_q == 2'd2) begin
							state_q <= S_WRITE;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						prod_q  <= mul_a * mul_b;
						state_q <= S_VDIV_GO;
					end
				end
				S_VDIV_GO: begin
					state_q <= S_VDIV;
				end
				S_VDIV: begin
					if (dv_done) begin
						vel_q[ax_q] <= dv_quot;
						if (ax_q == 2'd2) begin
							state_q <= S_WRITE;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_VMUL;
						end
					end
				end
				S_WRITE: begin
					tail_q       <= lmpq_pkg::next_ptr(tail_q);
					count_q      <= count_q + lmpq_pkg::CNT_W'(1);
					pos_q[0]     <= cur_q.x;
					pos_q[1]     <= cur_q.y;
					pos_q[2]     <= cur_q.z;
					res_q.status <= lmpq_pkg::ST_ACCEPTED;
					state_q      <= S_EMIT;
				end
				S_READ: begin
					res_q.status <= lmpq_pkg::ST_ISSUED;
					res_q.dir    <= rd_q.flags[2:0];
					res_q.travel <= rd_q.travel;
					res_q.vel    <= rd_q.vel;
					res_q.accel  <= rd_q.flags[3] ? rapid_accel_q : '0;
					head_q       <= lmpq_pkg::next_ptr(head_q);
					count_q      <= count_q - lmpq_pkg::CNT_W'(1);
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					// hand over the result and clear it for the next command
					if (emit_go) begin
						out_q   <= res_q;
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result ports
	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign dir_x     = out_q.dir[0];
	assign dir_y     = out_q.dir[1];
	assign dir_z     = out_q.dir[2];
	assign dist_x    = out_q.travel[0];
	assign dist_y    = out_q.travel[1];
	assign dist_z    = out_q.travel[2];
	assign vel_x     = out_q.vel[0];
	assign vel_y     = out_q.vel[1];
	assign vel_z     = out_q.vel[2];
	assign accel     = out_q.accel;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lmpq_pkg::CNT_W'(lmpq_pkg::QUEUE_DEPTH))
		else $error("move count above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && !q_full) |-> (head_q != tail_q))
		else $error("pointers meet on a partly filled queue");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && out_stall) |=> (state_q == S_EMIT))
		else $error("result left emit while output held");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> !q_full)
		else $error("move written into full queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/lmpq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpq_front
// Accepts commands, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module lmpq_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    command,
	input  wire logic [lmpq_pkg::COORD_W-1:0]  target_x,
	input  wire logic [lmpq_pkg::COORD_W-1:0]  target_y,
	input  wire logic [lmpq_pkg::COORD_W-1:0]  target_z,
	output logic                               item_valid,
	output lmpq_pkg::item_t                    item,
	input  wire logic                          item_pop
);

	lmpq_pkg::item_t buf_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	lmpq_pkg::item_t cls;
	logic            push;

	// classify the incoming command
	always_comb begin
		cls.rapid = 1'b0;
		cls.x     = target_x;
		cls.y     = target_y;
		cls.z     = target_z;
		unique case (lmpq_pkg::cmd_t'(command))
			lmpq_pkg::CMD_SET:   cls.kind = lmpq_pkg::K_SET;
			lmpq_pkg::CMD_RAPID: begin
				cls.kind  = lmpq_pkg::K_MOVE;
				cls.rapid = 1'b1;
			end
			lmpq_pkg::CMD_FEED:  cls.kind = lmpq_pkg::K_MOVE;
			default:             cls.kind = lmpq_pkg::K_DONE;
		endcase
	end

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = buf_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (item_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lmpq_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpq_sqrt
// Integer square root of the sum of squares, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module lmpq_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lmpq_pkg::SUM_W-1:0]  radicand,
	output logic                             done,
	output logic [lmpq_pkg::LEN_W-1:0]       root
);

	localparam int CNT_W = $clog2(lmpq_pkg::ROOT_STEPS + 1);

	logic [lmpq_pkg::SUM_W-1:0] rad_q;
	logic [lmpq_pkg::LEN_W-1:0] root_q;
	logic [lmpq_pkg::LEN_W:0]   rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lmpq_pkg::LEN_W+2:0] t;
	logic [lmpq_pkg::LEN_W+2:0] trial;

	// one digit of the root
	always_comb begin
		t     = {rem_q, rad_q[lmpq_pkg::SUM_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(lmpq_pkg::ROOT_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q <= {rad_q[lmpq_pkg::SUM_W-3:0], 2'b00};
				if (t >= trial) begin
					rem_q  <= (lmpq_pkg::LEN_W+1)'(t - trial);
					root_q <= {root_q[lmpq_pkg::LEN_W-2:0], 1'b1};
				end else begin
					rem_q  <= (lmpq_pkg::LEN_W+1)'(t);
					root_q <= {root_q[lmpq_pkg::LEN_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- rtl/lmpq_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpq_div
// Restoring divider for the axis velocity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmpq_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [lmpq_pkg::VEL_W+31:0]        dividend,
	input  wire logic [lmpq_pkg::LEN_W-1:0]         divisor,
	output logic                                    done,
	output logic [lmpq_pkg::VEL_W-1:0]              quotient
);

	localparam int CNT_W = $clog2(lmpq_pkg::DIV_STEPS + 1);
	localparam int DVD_W = lmpq_pkg::VEL_W + 32;

	logic [lmpq_pkg::LEN_W-1:0] rem_q;
	logic [lmpq_pkg::VEL_W-1:0] low_q;
	logic [lmpq_pkg::LEN_W-1:0] div_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lmpq_pkg::LEN_W:0]   t;
	logic [lmpq_pkg::LEN_W:0]   diff;

	// quotient fits the speed width, so the top part starts as remainder
	always_comb begin
		t    = {rem_q, low_q[lmpq_pkg::VEL_W-1]};
		diff = t - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			low_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {1'b0, dividend[DVD_W-1:lmpq_pkg::VEL_W]};
				low_q  <= dividend[lmpq_pkg::VEL_W-1:0];
				div_q  <= divisor;
				cnt_q  <= CNT_W'(lmpq_pkg::DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (t >= {1'b0, div_q}) begin
					rem_q <= diff[lmpq_pkg::LEN_W-1:0];
					low_q <= {low_q[lmpq_pkg::VEL_W-2:0], 1'b1};
				end else begin
					rem_q <= t[lmpq_pkg::LEN_W-1:0];
					low_q <= {low_q[lmpq_pkg::VEL_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule
`default_nettype wire
